// ===== sv/ocf_pkg.sv =====
package ocf_pkg;

  // Stack and counter sizes
  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int INDEX_BITS  = 16;
  localparam int POS_W       = 16;
  localparam int STATUS_W    = 2;
  localparam int CODE_W      = 3;
  localparam int CHAR_W      = 8;

  // Delimiter codes held on the stack
  localparam logic [CODE_W-1:0] D_NONE   = 3'd0;
  localparam logic [CODE_W-1:0] D_DQUOTE = 3'd1;
  localparam logic [CODE_W-1:0] D_SQUOTE = 3'd2;
  localparam logic [CODE_W-1:0] D_PAREN  = 3'd3;
  localparam logic [CODE_W-1:0] D_ANGLE  = 3'd4;
  localparam logic [CODE_W-1:0] D_BRACE  = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

  // Characters of interest
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LANGLE = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_RANGLE = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CODE_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== sv/outer_comma_finder.sv =====
// Finds the first comma at nesting depth zero in a string that arrives one
// character per item, last_char marking the final one. One item is accepted
// every cycle while the result buffer has room; a result is registered in
// its head, or its skid stage when the head stalls. The open-delimiter stack
// lives in a RAM of STACK_DEPTH entries with a registered read: the top entry
// is kept in a register and the entry below it is read from the RAM on every
// cycle, so pushes and pops can follow each other back to back. The stack RAM
// needs no clearing after reset; only pushed entries are ever used. Status 0
// gives the comma's index in position, counted from 0; the other statuses give
// position 0. Characters after the deciding one are dropped until last_char.
module outer_comma_finder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic [ocf_pkg::CHAR_W-1:0]        character,
  input  logic                              last_char,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [ocf_pkg::STATUS_W-1:0]      status,
  output logic [ocf_pkg::POS_W-1:0]         position
);
  import ocf_pkg::*;

  logic [DEPTH_W-1:0]    depth;
  logic [DEPTH_W-1:0]    depth_next;
  logic [CODE_W-1:0]     top;
  logic [CODE_W-1:0]     top_next;
  logic [INDEX_BITS-1:0] char_index;
  logic                  decided;

  logic [CODE_W-1:0]     below;
  ram_req_t              ram_req;
  logic [DEPTH_W-1:0]    rd_sum;

  logic                  fire;
  logic                  act;
  logic [CODE_W-1:0]     top_eff;
  logic                  full;
  logic [CODE_W-1:0]     opener;
  logic [CODE_W-1:0]     closer;
  logic                  quote_pop;
  logic                  comma;
  logic                  do_push;
  logic                  do_pop;
  logic                  overflow;
  logic                  mismatch;
  logic                  found;
  logic                  fin;
  logic                  res_push;
  result_t               res;
  result_t               out_data;

  assign fire    = item_valid && item_ready;
  assign act     = fire && !decided;
  assign top_eff = (depth == '0) ? D_NONE : top;
  assign full    = (depth == DEPTH_W'(STACK_DEPTH));

  // Classify the character against the top of the stack
  always_comb begin
    opener    = D_NONE;
    closer    = D_NONE;
    quote_pop = 1'b0;
    comma     = 1'b0;
    if (character == CH_DQUOTE) begin
      if (top_eff == D_DQUOTE) begin
        quote_pop = 1'b1;
      end else begin
        opener = D_DQUOTE;
      end
    end else if (top_eff != D_DQUOTE) begin
      unique case (character)
        CH_SQUOTE: begin
          if (top_eff == D_SQUOTE) begin
            quote_pop = 1'b1;
          end else begin
            opener = D_SQUOTE;
          end
        end
        CH_LPAREN: opener = D_PAREN;
        CH_LANGLE: opener = D_ANGLE;
        CH_LBRACE: opener = D_BRACE;
        CH_RPAREN: closer = D_PAREN;
        CH_RANGLE: closer = D_ANGLE;
        CH_RBRACE: closer = D_BRACE;
        CH_COMMA:  comma  = 1'b1;
        default: ;
      endcase
    end
  end

  assign overflow = (opener != D_NONE) && full;
  assign do_push  = act && (opener != D_NONE) && !full;
  assign mismatch = (closer != D_NONE) && (top_eff != closer);
  assign do_pop   = act && (quote_pop || ((closer != D_NONE) && (top_eff == closer)));
  assign found    = comma && (depth == '0);
  assign fin      = overflow || mismatch || found || last_char;
  assign res_push = act && fin;

  // Pick the status of a deciding character
  always_comb begin
    res.position = '0;
    priority if (found) begin
      res.status   = ST_FOUND;
      res.position = POS_W'(char_index);
    end else if (overflow) begin
      res.status = ST_OVERFLOW;
    end else if (mismatch) begin
      res.status = ST_MISMATCH;
    end else begin
      res.status = ST_NONE;
    end
  end

  // Advance depth and top of stack
  always_comb begin
    depth_next = depth;
    top_next   = top;
    if (fire && last_char) begin
      depth_next = '0;
    end else if (do_push) begin
      depth_next = depth + DEPTH_W'(1);
      top_next   = opener;
    end else if (do_pop) begin
      depth_next = depth - DEPTH_W'(1);
      top_next   = below;
    end
  end

  // Write pushed codes; prefetch the entry under the next top
  assign rd_sum        = depth_next - DEPTH_W'(2);
  assign ram_req.we    = do_push;
  assign ram_req.waddr = depth[ADDR_W-1:0];
  assign ram_req.wdata = opener;
  assign ram_req.raddr = rd_sum[ADDR_W-1:0];

  ocf_stack_ram u_stack_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (below)
  );

  // Hold stack pointer, index and decided flag; clear them after the last item
  always_ff @(posedge clk) begin
    if (rst) begin
      depth      <= '0;
      char_index <= '0;
      decided    <= 1'b0;
    end else begin
      depth <= depth_next;
      if (fire) begin
        if (last_char) begin
          char_index <= '0;
          decided    <= 1'b0;
        end else begin
          char_index <= char_index + INDEX_BITS'(1);
          decided    <= decided || fin;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
  end

  ocf_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .can_push  (item_ready),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_data  (out_data)
  );

  assign status   = out_data.status;
  assign position = out_data.position;

  // Stack pointer never passes the stack size
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond stack size");

  // Last item clears the string state
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    fire && last_char |=> depth == '0 && char_index == '0 && !decided)
    else $error("string state not cleared after last item");

  // No result for an item of a decided string
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    fire && decided |-> !res_push)
    else $error("result from a decided string");

  // Position is zero unless a comma was found
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_FOUND |-> position == '0)
    else $error("nonzero position without a found comma");

endmodule

// ===== sv/ocf_stack_ram.sv =====
module ocf_stack_ram (
  input  logic                                 clk,
  input  ocf_pkg::ram_req_t                    req,
  output logic [ocf_pkg::CODE_W-1:0]           rdata
);
  import ocf_pkg::*;

  logic [CODE_W-1:0] mem [STACK_DEPTH];

  // Read one entry each cycle, and write one entry when we is set
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== sv/ocf_out_buf.sv =====
module ocf_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ocf_pkg::result_t   push_data,
  output logic               can_push,
  output logic               out_valid,
  input  logic               out_ready,
  output ocf_pkg::result_t   out_data
);
  import ocf_pkg::*;

  logic    head_v;
  result_t head;
  logic    skid_v;
  result_t skid;
  logic    pop;

  assign pop       = head_v && out_ready;
  assign can_push  = !skid_v;
  assign out_valid = head_v;
  assign out_data  = head;

  // Hold a result in the head; spill to the skid stage when the head is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      head_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (pop) begin
        head   <= skid;
        skid_v <= 1'b0;
      end
    end else if (push) begin
      if (!head_v || pop) begin
        head   <= push_data;
        head_v <= 1'b1;
      end else begin
        skid   <= push_data;
        skid_v <= 1'b1;
      end
    end else if (pop) begin
      head_v <= 1'b0;
    end
  end

endmodule

// ===== test/ocf_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the comma finder, tracks the nesting of each string
// from the accepted items and checks every result against the oldest
// outcome still owed.
module ocf_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  logic                         item_ready,
  input  logic [ocf_pkg::CHAR_W-1:0]   character,
  input  logic                         last_char,
  input  logic                         result_valid,
  input  logic                         result_ready,
  input  logic [ocf_pkg::STATUS_W-1:0] status,
  input  logic [ocf_pkg::POS_W-1:0]    position,
  output int unsigned                  mismatches,
  output int unsigned                  owed,
  output int unsigned                  compared
);

  import ocf_pkg::*;

  // Shadow copy of the string state
  logic [CODE_W-1:0]     open_stack [STACK_DEPTH];
  int                    open_count;
  logic [INDEX_BITS-1:0] char_pos;
  bit                    settled;

  // Outcomes waiting for their result item
  result_t owed_results [$];

  // Advance the string state by one character; queue the outcome if it decides
  task automatic scan_character(input logic [CHAR_W-1:0] ch, input logic last);
    logic [CODE_W-1:0] top;
    logic [CODE_W-1:0] opener;
    logic [CODE_W-1:0] closer;
    bit                fin;
    result_t           res;
    top    = (open_count == 0) ? D_NONE : open_stack[open_count-1];
    opener = D_NONE;
    closer = D_NONE;
    fin    = 1'b0;
    res.status   = ST_NONE;
    res.position = '0;
    if (!settled) begin
      // Inside a double quote only another double quote matters
      if (ch == CH_DQUOTE) begin
        if (top == D_DQUOTE) open_count--;
        else opener = D_DQUOTE;
      end else if (top != D_DQUOTE) begin
        case (ch)
          CH_SQUOTE: begin
            if (top == D_SQUOTE) open_count--;
            else opener = D_SQUOTE;
          end
          CH_LPAREN: opener = D_PAREN;
          CH_LANGLE: opener = D_ANGLE;
          CH_LBRACE: opener = D_BRACE;
          CH_RPAREN: closer = D_PAREN;
          CH_RANGLE: closer = D_ANGLE;
          CH_RBRACE: closer = D_BRACE;
          CH_COMMA: begin
            if (open_count == 0) begin
              fin          = 1'b1;
              res.status   = ST_FOUND;
              res.position = char_pos[POS_W-1:0];
            end
          end
          default: ;
        endcase
      end
      // Push an opener, or pop a matching closer
      if (opener != D_NONE) begin
        if (open_count >= STACK_DEPTH) begin
          fin        = 1'b1;
          res.status = ST_OVERFLOW;
        end else begin
          open_stack[open_count] = opener;
          open_count++;
        end
      end else if (closer != D_NONE) begin
        if (top == closer) begin
          open_count--;
        end else begin
          fin        = 1'b1;
          res.status = ST_MISMATCH;
        end
      end
      if (!fin && last) begin
        fin        = 1'b1;
        res.status = ST_NONE;
      end
      if (fin) begin
        settled = 1'b1;
        owed_results.push_back(res);
      end
    end
    char_pos++;
    // Clear everything after the final character
    if (last) begin
      open_count = 0;
      char_pos   = '0;
      settled    = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      open_count = 0;
      char_pos   = '0;
      settled    = 1'b0;
      owed_results.delete();
      mismatches = 0;
      compared   = 0;
    end else begin
      if (item_valid && item_ready) scan_character(character, last_char);
      // Compare the result item with the oldest outcome
      if (result_valid && result_ready) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: expected none, actual status %0d position %0d",
                   $time, status, position);
        end else begin
          want = owed_results.pop_front();
          compared++;
          if (status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          end
          if (position !== want.position) begin
            mismatches++;
            $display("%0t: position expected %0d actual %0d", $time, want.position, position);
          end
        end
      end
    end
    owed = owed_results.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  import ocf_pkg::*;

  localparam int RANDOM_ITEMS   = 300;
  localparam int MAX_GAP        = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                item_valid   = 1'b0;
  logic                item_ready;
  logic [CHAR_W-1:0]   character    = '0;
  logic                last_char    = 1'b0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;

  int unsigned mismatches;
  int unsigned owed;
  int unsigned compared;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned sent_items = 0;
  int unsigned strings_sent = 0;
  int unsigned quiet_cycles = 0;

  logic [CHAR_W-1:0] text_q [$];

  always #1 clk = ~clk;

  outer_comma_finder u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .character    (character),
    .last_char    (last_char),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .position     (position)
  );

  ocf_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .character    (character),
    .last_char    (last_char),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .position     (position),
    .mismatches   (mismatches),
    .owed         (owed),
    .compared     (compared)
  );

  // Stall the result channel at random
  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else result_ready <= ($urandom_range(99) >= stall_pct);
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $time, quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one character, with an optional idle gap first
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
      gap++;
    end
    item_valid <= 1'b1;
    character  <= c;
    last_char  <= last;
    sent_items++;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    strings_sent++;
  endtask

  task automatic send_word(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  // Send count copies of one character, none of them last
  task automatic send_run(input logic [CHAR_W-1:0] c, input int count);
    for (int i = 0; i < count; i++) send_char(c, 1'b0);
  endtask

  // Hold the sender until every owed result has come back
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] delim_char(input logic [CODE_W-1:0] code,
                                                   input bit closing);
    case (code)
      D_DQUOTE: return CH_DQUOTE;
      D_SQUOTE: return CH_SQUOTE;
      D_PAREN:  return closing ? CH_RPAREN : CH_LPAREN;
      D_ANGLE:  return closing ? CH_RANGLE : CH_LANGLE;
      default:  return closing ? CH_RBRACE : CH_LBRACE;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] any_delim();
    case ($urandom_range(8))
      0: return CH_DQUOTE;
      1: return CH_SQUOTE;
      2: return CH_LPAREN;
      3: return CH_RPAREN;
      4: return CH_LANGLE;
      5: return CH_RANGLE;
      6: return CH_LBRACE;
      7: return CH_RBRACE;
      default: return CH_COMMA;
    endcase
  endfunction

  // Any byte that neither opens, closes nor splits
  function automatic logic [CHAR_W-1:0] plain_byte();
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom_range(255));
    case (c)
      CH_DQUOTE, CH_SQUOTE, CH_LPAREN, CH_RPAREN, CH_LANGLE, CH_RANGLE,
      CH_LBRACE, CH_RBRACE, CH_COMMA: c = 8'h61;
      default: ;
    endcase
    return c;
  endfunction

  // Build a properly nested string with random content into text_q
  task automatic build_balanced(input int len, input int max_nest, input int close_pct);
    logic [CODE_W-1:0] nest [$];
    logic [CODE_W-1:0] code;
    logic [CHAR_W-1:0] c;
    int roll;
    text_q.delete();
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(99);
      if (nest.size() != 0 && nest[nest.size()-1] == D_DQUOTE) begin
        // anything but a double quote is inert inside one
        if (roll < 25) begin
          code = nest.pop_back();
          text_q.push_back(CH_DQUOTE);
        end else begin
          c = CHAR_W'($urandom_range(255));
          if (c == CH_DQUOTE) c = CH_COMMA;
          text_q.push_back(c);
        end
      end else if (nest.size() != 0 && roll < close_pct) begin
        code = nest.pop_back();
        text_q.push_back(delim_char(code, 1'b1));
      end else if (roll < 55 && nest.size() < max_nest) begin
        code = CODE_W'($urandom_range(D_BRACE, D_DQUOTE));
        if (code == D_SQUOTE && nest.size() != 0 && nest[nest.size()-1] == D_SQUOTE)
          code = D_PAREN;
        nest.push_back(code);
        text_q.push_back(delim_char(code, 1'b0));
      end else if (roll < 68) begin
        text_q.push_back(CH_COMMA);
      end else begin
        text_q.push_back(plain_byte());
      end
    end
    // close what is still open
    while (nest.size() != 0) begin
      code = nest.pop_back();
      text_q.push_back(delim_char(code, 1'b1));
    end
  endtask

  initial begin
    int unsigned target;
    int          roll;
    int          len;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Short directed strings: every delimiter, every status but overflow, zero and top bytes
    send_word(",");
    text_q.delete();
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    send_text();
    send_word("(,),");
    send_word("(>");
    send_word("}ab");
    send_word("\",(\",");
    send_word("'(')");
    send_word("<>{}");
    text_q.delete();
    text_q.push_back(8'h00);
    text_q.push_back(CH_COMMA);
    text_q.push_back(8'h80);
    send_text();

    // Stack full and one opener more, then an ignored last byte
    send_run(CH_LPAREN, STACK_DEPTH + 1);
    send_char(8'h78, 1'b1);
    strings_sent++;
    drain();

    // Random strings under four idling mixes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      target = sent_items + RANDOM_ITEMS / 4;
      while (sent_items < target) begin
        roll = $urandom_range(99);
        if (roll < 10) begin
          // noise
          text_q.delete();
          len = $urandom_range(16, 1);
          for (int i = 0; i < len; i++)
            text_q.push_back($urandom_range(1) ? any_delim() : 8'($urandom_range(255)));
        end else if (roll < 25) begin
          // nested string with one character broken
          build_balanced($urandom_range(20, 1), 8, 30);
          text_q[$urandom_range(text_q.size() - 1)] = any_delim();
        end else if (roll < 30) begin
          build_balanced($urandom_range(80, 20), 60, 8);
        end else begin
          build_balanced($urandom_range(20, 1), 8, 30);
        end
        send_text();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d strings, %0d characters: directed strings, a stack overflow",
             strings_sent, sent_items);
    $display("and random nested, broken and noise strings; %0d results compared", compared);
    if (mismatches == 0 && owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== outer_comma_finder.f =====
sv/ocf_pkg.sv
sv/ocf_stack_ram.sv
sv/ocf_out_buf.sv
sv/outer_comma_finder.sv
test/ocf_checker.sv
test/tb.sv
